[design/slm_pkg.sv]
// package for the single-linkage merge step block
// constants, operation and status codes, triangle position helper
package slm_pkg;
  localparam int MaxClusters = 64;
  localparam int DistBits = 16;
  localparam int StoreDepth = MaxClusters * (MaxClusters - 1) / 2;
  localparam int AddrBits = $clog2(StoreDepth);
  localparam int IdxBits = 6;
  localparam int CntBits = 7;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_MERGE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_TOO_FEW = 2'd2;

  // r*(r-1)/2 + c for r > c
  function automatic logic [AddrBits-1:0] tri_pos(input logic [IdxBits-1:0] r,
                                                  input logic [IdxBits-1:0] c);
    logic [2*IdxBits-1:0] prod;
    begin
      prod = {{IdxBits{1'b0}}, r} * {{IdxBits{1'b0}}, r - IdxBits'(1)};
      tri_pos = AddrBits'(prod >> 1) + AddrBits'(c);
    end
  endfunction
endpackage

[design/slm_ram.sv]
// generic single-port ram with registered read
// no dependencies
module slm_ram #(
  parameter int Width = 16,
  parameter int Depth = 2016
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[design/single_linkage_merge_step.sv]
// single_linkage_merge_step top level: sequencer around one distance ram
// depends on slm_pkg and slm_ram
//
//  channel  | signals                                   | direction
//  in       | in_valid, in_stall, kind..distance_in     | beat in
//  out      | out_valid, out_stall, status..clusters_left | beat out
//  cfg      | cfg_valid, cfg_ready, cfg_data            | register write
//
// a write goes through S_DONE, a read through S_RDWT and S_DONE; no-op and rejects answer from S_IDLE
// a merge scans every triangle entry (S_SCAN, S_SCANW), updates each other cluster (S_UPA, S_UPB, S_UPW),
// then compacts the triangle when more than two clusters were live (S_CPR, S_CPW); all on the one ram port
// one item is worked at a time; the result register holds while out_stall is high
// rst is synchronous; ram contents are undefined until written, no clearing pass
module single_linkage_merge_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [5:0]  row_index,
  input  logic [5:0]  col_index,
  input  logic [15:0] distance_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  pair_row,
  output logic [5:0]  pair_col,
  output logic [15:0] distance_out,
  output logic [6:0]  clusters_left,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);
  import slm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RDWT  = 10'b0000000010,
    S_SCAN  = 10'b0000000100,
    S_SCANW = 10'b0000001000,
    S_UPA   = 10'b0000010000,
    S_UPB   = 10'b0000100000,
    S_UPW   = 10'b0001000000,
    S_CPR   = 10'b0010000000,
    S_CPW   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state;
  logic [CntBits-1:0] matrix_size, live_count, n;
  logic [1:0] op_kind;
  logic [IdxBits-1:0] op_row, op_col;
  logic [DistBits-1:0] op_din, best, tmp;
  logic [IdxBits-1:0] br, bc, r, c;
  logic [AddrBits-1:0] p;
  logic first;

  logic ram_we;
  logic [AddrBits-1:0] ram_addr;
  logic [DistBits-1:0] ram_wdata, ram_rdata;

  slm_ram #(.Width(DistBits), .Depth(StoreDepth)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic [CntBits-1:0] eff_size;
  assign eff_size = (matrix_size > CntBits'(MaxClusters)) ? CntBits'(MaxClusters)
                                                          : matrix_size;
  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE) || out_valid;

  // row counter runs one past the last index, so it is one bit wider
  logic [CntBits-1:0] rw, cw;
  assign r = rw[IdxBits-1:0];
  assign cw = {1'b0, c};

  // pair (k, x) ordered for the triangle
  function automatic logic [AddrBits-1:0] pos2(input logic [IdxBits-1:0] a,
                                               input logic [IdxBits-1:0] b);
    pos2 = (a > b) ? tri_pos(a, b) : tri_pos(b, a);
  endfunction

  logic [IdxBits-1:0] orow, ocol;
  assign orow = r + ((r >= br) ? IdxBits'(1) : IdxBits'(0));
  assign ocol = c + ((c >= br) ? IdxBits'(1) : IdxBits'(0));

  always_comb begin
    ram_we = 1'b0;
    ram_addr = tri_pos(op_row, op_col);
    ram_wdata = op_din;
    unique case (state)
      S_SCAN: ram_addr = tri_pos(r, c);
      S_UPA:  ram_addr = pos2(r, bc);
      S_UPB:  ram_addr = pos2(r, br);
      S_UPW: begin
        ram_addr = pos2(r, bc);
        ram_we = 1'b1;
        ram_wdata = (tmp < ram_rdata) ? tmp : ram_rdata;
      end
      S_CPR:  ram_addr = tri_pos(orow, ocol);
      S_CPW: begin
        ram_addr = p;
        ram_we = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_DONE: ram_we = (op_kind == KIND_WRITE);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      matrix_size <= 7'd6;
      live_count <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        matrix_size <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op_kind <= kind;
            op_row <= row_index;
            op_col <= col_index;
            op_din <= distance_in;
            pair_row <= row_index;
            pair_col <= col_index;
            distance_out <= '0;
            status <= ST_BAD_INDEX;
            clusters_left <= live_count;
            if (kind == KIND_WRITE) begin
              if ({1'b0, row_index} < eff_size && col_index < row_index) begin
                status <= ST_OK;
                distance_out <= distance_in;
                live_count <= eff_size;
                clusters_left <= eff_size;
                state <= S_DONE;
              end else begin
                out_valid <= 1'b1;
              end
            end else if (kind == KIND_READ) begin
              if ({1'b0, row_index} < live_count && col_index < row_index) begin
                status <= ST_OK;
                state <= S_RDWT;
              end else begin
                out_valid <= 1'b1;
              end
            end else if (kind == KIND_MERGE) begin
              n <= (live_count > CntBits'(MaxClusters)) ? CntBits'(MaxClusters)
                                                        : live_count;
              if (live_count < 7'd2) begin
                status <= ST_TOO_FEW;
                pair_row <= '0;
                pair_col <= '0;
                out_valid <= 1'b1;
              end else begin
                rw <= 7'd1;
                c <= '0;
                br <= 6'd1;
                bc <= '0;
                first <= 1'b1;
                state <= S_SCAN;
              end
            end else begin
              pair_row <= '0;
              pair_col <= '0;
              out_valid <= 1'b1;
            end
          end
        end
        S_RDWT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (op_kind == KIND_READ) begin
            distance_out <= ram_rdata;
          end
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_SCAN: begin
          op_row <= r;
          op_col <= c;
          if (cw + 7'd1 < rw) begin
            c <= c + 6'd1;
          end else begin
            c <= '0;
            rw <= rw + 7'd1;
          end
          state <= S_SCANW;
        end
        S_SCANW: begin
          if (first || ram_rdata < best) begin
            best <= ram_rdata;
            br <= op_row;
            bc <= op_col;
          end
          first <= 1'b0;
          if (rw < n) begin
            state <= S_SCAN;
          end else begin
            rw <= '0;
            state <= S_UPA;
          end
        end
        S_UPA: begin
          if (rw >= n) begin
            rw <= 7'd1;
            c <= '0;
            p <= '0;
            if (n > 7'd2) begin
              state <= S_CPR;
            end else begin
              state <= S_IDLE;
              live_count <= n - 7'd1;
              clusters_left <= n - 7'd1;
              status <= ST_OK;
              pair_row <= br;
              pair_col <= bc;
              distance_out <= best;
              out_valid <= 1'b1;
            end
          end else if (r == bc || r == br) begin
            rw <= rw + 7'd1;
          end else begin
            state <= S_UPB;
          end
        end
        S_UPB: begin
          tmp <= ram_rdata;
          state <= S_UPW;
        end
        S_UPW: begin
          rw <= rw + 7'd1;
          state <= S_UPA;
        end
        S_CPR: begin
          state <= S_CPW;
        end
        S_CPW: begin
          p <= p + AddrBits'(1);
          if (cw + 7'd1 < rw) begin
            c <= c + 6'd1;
            state <= S_CPR;
          end else if (rw + 7'd2 < n) begin
            c <= '0;
            rw <= rw + 7'd1;
            state <= S_CPR;
          end else begin
            state <= S_IDLE;
            live_count <= n - 7'd1;
            clusters_left <= n - 7'd1;
            status <= ST_OK;
            pair_row <= br;
            pair_col <= bc;
            distance_out <= best;
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= CntBits'(MaxClusters)) else $error("live count overflow");
  a_merge_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPA) |-> (br > bc)) else $error("bad merge pair");
`endif
endmodule

[tb/merge_step_checker.sv]
`timescale 1ns / 100ps
// checker for single_linkage_merge_step: keeps its own distance triangle and live count,
// predicts every result beat and compares it field by field. depends on slm_pkg
module merge_step_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [5:0]  row_index,
  input  logic [5:0]  col_index,
  input  logic [15:0] distance_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [5:0]  pair_row,
  input  logic [5:0]  pair_col,
  input  logic [15:0] distance_out,
  input  logic [6:0]  clusters_left,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output int          fails,
  output int          pending
);
  import slm_pkg::*;

  typedef struct {
    logic [1:0]  st;
    logic [5:0]  r;
    logic [5:0]  c;
    logic [15:0] d;
    logic [6:0]  left;
  } step_result_t;

  logic [15:0] dist_mem [StoreDepth];
  int live_clusters;
  int size_reg;
  step_result_t awaited_results[$];

  function automatic int tri_at(int a, int b);
    int hi;
    int lo;
    hi = a > b ? a : b;
    lo = a > b ? b : a;
    return hi * (hi > 0 ? hi - 1 : 0) / 2 + lo;
  endfunction

  function automatic int eff_size();
    return size_reg > MaxClusters ? MaxClusters : size_reg;
  endfunction

  function automatic step_result_t merge_or_access(logic [1:0] k, logic [5:0] r,
                                                   logic [5:0] c, logic [15:0] d);
    step_result_t res;
    int n;
    int br;
    int bc;
    int p;
    int orow;
    int ocol;
    logic [15:0] best;
    logic [15:0] a;
    logic [15:0] b;
    res.st = ST_OK;
    res.r = r;
    res.c = c;
    res.d = '0;
    case (k)
      KIND_WRITE: begin
        if (r < eff_size() && c < r) begin
          dist_mem[tri_at(r, c)] = d;
          live_clusters = eff_size();
          res.d = d;
        end else res.st = ST_BAD_INDEX;
      end
      KIND_READ: begin
        if (r < live_clusters && c < r) res.d = dist_mem[tri_at(r, c)];
        else res.st = ST_BAD_INDEX;
      end
      KIND_MERGE: begin
        n = live_clusters > MaxClusters ? MaxClusters : live_clusters;
        if (n < 2) begin
          res.st = ST_TOO_FEW;
          res.r = '0;
          res.c = '0;
        end else begin
          br = 1;
          bc = 0;
          best = dist_mem[0];
          for (int i = 1; i < n; i++)
            for (int j = 0; j < i; j++)
              if (dist_mem[tri_at(i, j)] < best) begin
                best = dist_mem[tri_at(i, j)];
                br = i;
                bc = j;
              end
          // bc absorbs br: keep the closer of the two links to every other cluster
          for (int q = 0; q < n; q++) begin
            if (q == bc || q == br) continue;
            a = dist_mem[tri_at(q, bc)];
            b = dist_mem[tri_at(q, br)];
            dist_mem[tri_at(q, bc)] = a < b ? a : b;
          end
          p = 0;
          for (int i = 1; i + 1 < n; i++) begin
            orow = i + (i >= br ? 1 : 0);
            for (int j = 0; j < i; j++) begin
              ocol = j + (j >= br ? 1 : 0);
              dist_mem[p] = dist_mem[tri_at(orow, ocol)];
              p++;
            end
          end
          live_clusters = n - 1;
          res.r = 6'(br);
          res.c = 6'(bc);
          res.d = best;
        end
      end
      default: begin
        res.st = ST_BAD_INDEX;
        res.r = '0;
        res.c = '0;
      end
    endcase
    res.left = 7'(live_clusters);
    return res;
  endfunction

  task automatic report(string field, int got, int want);
    $display("%0t: mismatch on %s, got %0d want %0d", $realtime, field, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    step_result_t exp_beat;
    if (rst) begin
      fails = 0;
      live_clusters = 0;
      size_reg = 6;
      awaited_results.delete();
    end else begin
      // results of earlier beats are retired before a new beat is predicted
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) report("unexpected result beat", 1, 0);
        else begin
          exp_beat = awaited_results.pop_front();
          if (status !== exp_beat.st) report("status", status, exp_beat.st);
          if (pair_row !== exp_beat.r) report("pair_row", pair_row, exp_beat.r);
          if (pair_col !== exp_beat.c) report("pair_col", pair_col, exp_beat.c);
          if (distance_out !== exp_beat.d) report("distance_out", distance_out, exp_beat.d);
          if (clusters_left !== exp_beat.left)
            report("clusters_left", clusters_left, exp_beat.left);
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(merge_or_access(kind, row_index, col_index, distance_in));
      if (cfg_valid && cfg_ready) size_reg = cfg_data;
    end
    pending = awaited_results.size();
  end
endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// top of the single_linkage_merge_step testbench: clock, reset, stimulus and verdict
// depends on slm_pkg, single_linkage_merge_step and merge_step_checker
module tb;
  import slm_pkg::*;

  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam int Limit = 3_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = KIND_NOP;
  logic [5:0]  row_index = '0;
  logic [5:0]  col_index = '0;
  logic [15:0] distance_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [5:0]  pair_row;
  logic [5:0]  pair_col;
  logic [15:0] distance_out;
  logic [6:0]  clusters_left;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;

  int fails;
  int pending;
  int cycles = 0;
  int hold_left = 0;
  int sent = 0;
  bit quiet = 1'b0;
  bit tie_data = 1'b0;

  // stimulus-side bookkeeping so that no never-written entry is ever read
  bit written [StoreDepth];
  int live = 0;
  int size_now = 6;

  single_linkage_merge_step u_top (.*);

  merge_step_checker u_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > Limit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) hold_left = quiet ? 0 : $urandom_range(0, 13);
      else if (hold_left > 0) hold_left--;
      out_stall <= hold_left != 0;
    end
  end

  function automatic int eff_size();
    return size_now > MaxClusters ? MaxClusters : size_now;
  endfunction

  function automatic bit merge_safe();
    for (int p = 0; p < live * (live - 1) / 2; p++)
      if (!written[p]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send(logic [1:0] k, logic [5:0] r, logic [5:0] c, logic [15:0] d);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    row_index <= r;
    col_index <= c;
    distance_in <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (k == KIND_WRITE && r < eff_size() && c < r) begin
      written[tri_pos(r, c)] = 1'b1;
      live = eff_size();
    end else if (k == KIND_MERGE && live >= 2) live--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_size(logic [6:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    size_now = v;
  endtask

  function automatic logic [15:0] pick_distance();
    int sel;
    sel = $urandom_range(0, 19);
    if (tie_data) return 16'($urandom_range(0, 3));
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hffff;
    return 16'($urandom);
  endfunction

  task automatic load_matrix(int n);
    for (int r = 1; r < n; r++)
      for (int c = 0; c < r; c++) send(KIND_WRITE, 6'(r), 6'(c), pick_distance());
  endtask

  task automatic random_op();
    int sel;
    logic [5:0] r;
    logic [5:0] c;
    sel = $urandom_range(0, 99);
    r = 6'($urandom);
    c = 6'($urandom);
    if (sel < 40 && merge_safe()) send(KIND_MERGE, '0, '0, 16'($urandom));
    else if (sel < 75) begin
      if (sel % 4 != 0 && live >= 2) begin
        r = 6'($urandom_range(1, live - 1));
        c = 6'($urandom_range(0, r - 1));
      end
      if (r < live && c < r && !written[tri_pos(r, c)]) c = r;
      send(KIND_READ, r, c, 16'($urandom));
    end else if (sel < 90) begin
      if (sel % 2 == 0) begin
        r = 6'($urandom_range(1, eff_size() - 1));
        c = 6'($urandom_range(0, r - 1));
      end
      send(KIND_WRITE, r, c, pick_distance());
    end else send(KIND_NOP, r, c, 16'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty block: merge with nothing live, read with nothing live, idle code, bad-index writes
    send(KIND_MERGE, 6'd0, 6'd0, 16'd0);
    send(KIND_READ, 6'd1, 6'd0, 16'd0);
    send(KIND_NOP, 6'd63, 6'd63, 16'hffff);
    send(KIND_WRITE, 6'd6, 6'd0, 16'd5);
    send(KIND_WRITE, 6'd3, 6'd3, 16'd5);
    send(KIND_WRITE, 6'd2, 6'd5, 16'd5);

    // smallest matrix, merged down to one cluster and then merged once more
    set_size(7'd2);
    send(KIND_WRITE, 6'd1, 6'd0, 16'hffff);
    send(KIND_READ, 6'd1, 6'd0, 16'd0);
    send(KIND_READ, 6'd2, 6'd0, 16'd0);
    send(KIND_MERGE, 6'd0, 6'd0, 16'd0);
    send(KIND_MERGE, 6'd0, 6'd0, 16'd0);
    send(KIND_READ, 6'd1, 6'd0, 16'd0);

    // all distances equal: the first pair in scan order wins
    set_size(7'd4);
    for (int r = 1; r < 4; r++)
      for (int c = 0; c < r; c++) send(KIND_WRITE, 6'(r), 6'(c), 16'd9);
    send(KIND_MERGE, 6'd0, 6'd0, 16'd0);
    send(KIND_MERGE, 6'd0, 6'd0, 16'd0);

    // oversized setting clamps to the full 64 clusters
    set_size(7'd127);
    send(KIND_WRITE, 6'd63, 6'd62, 16'd77);
    send(KIND_READ, 6'd63, 6'd62, 16'd0);
    send(KIND_WRITE, 6'd63, 6'd63, 16'd0);

    while (sent < 140) begin
      quiet = $urandom_range(0, 3) == 0;
      tie_data = $urandom_range(0, 2) == 0;
      set_size($urandom_range(0, 5) == 0 ? 7'd64 : 7'($urandom_range(2, 8)));
      if (size_now == 64) begin
        // a big matrix only sees three random operations, its triangle is never fully loaded
        for (int i = 0; i < 3; i++) random_op();
      end else begin
        load_matrix(size_now);
        for (int i = 0; i < 10; i++) random_op();
      end
    end

    drain();
    if (fails == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
